// ===== rtl/weighted_color_blend_assert.svh =====
// Assertion macros shared by the weighted colour blend RTL.
`ifndef WEIGHTED_COLOR_BLEND_ASSERT_SVH
`define WEIGHTED_COLOR_BLEND_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset
`define WCB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("weighted_color_blend: assertion failed");

// Checked on every rising edge, reset included
`define WCB_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("weighted_color_blend: reset assertion failed");

`else

`define WCB_ASSERT(lbl, prop)
`define WCB_ASSERT_RST(lbl, prop)

`endif

`endif

// ===== rtl/wcb_pkg.sv =====
// Package: widths, register codes, reset values and types of the colour blender.
package wcb_pkg;

	// field and lane counts
	localparam int W_W     = 16;   // one Q1.15 weight
	localparam int N_W     = 4;    // weights per item
	localparam int C_W     = 8;    // one colour channel
	localparam int N_CH    = 4;    // red, green, blue, alpha
	localparam int RGBA_W  = 32;
	localparam int S_DATA_W = N_W * W_W;
	localparam int M_DATA_W = N_CH * C_W;

	// datapath widths
	localparam int SUM_W   = 18;   // sum of four weights
	localparam int PROD_W  = 24;   // channel * weight
	localparam int ACC_W   = 26;   // sum of four products
	localparam int CDEF_W  = 16;   // default weight, at most 32768
	localparam int DAC_W   = 23;   // default alpha * default weight
	localparam int S255_W  = 26;   // 255 * weight sum
	localparam int A255_W  = 34;   // 255 * product sum
	localparam int NUM_W   = 35;   // dividend
	localparam int DEN_W   = 27;   // divisor
	localparam int REM_W   = NUM_W + 1;   // 2*num + den
	localparam int DVS_W   = DEN_W + 1;   // 2*den
	localparam int Q_W     = 8;

	localparam int ONE_Q15 = 32768;

	// channel order in the lanes
	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;
	localparam int CH_A = 3;

	// pipeline depth
	localparam int FRONT_ST = 4;
	localparam int DIV_ST   = 10;
	localparam int PIPE_ST  = FRONT_ST + DIV_ST + 1;

	// configuration register indexes
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_DEFAULT  = 3'd0;
	localparam logic [IDX_W-1:0] REG_FIRST    = 3'd1;
	localparam logic [IDX_W-1:0] REG_SECOND   = 3'd2;
	localparam logic [IDX_W-1:0] REG_THIRD    = 3'd3;
	localparam logic [IDX_W-1:0] REG_FOURTH   = 3'd4;
	localparam logic [IDX_W-1:0] REG_ALPHA_EN = 3'd5;

	// reset values
	localparam logic [RGBA_W-1:0] RST_DEFAULT = 32'h0000_00FF;
	localparam logic [RGBA_W-1:0] RST_FIRST   = 32'hFFFF_FFFF;
	localparam logic [RGBA_W-1:0] RST_SECOND  = 32'hFF00_00FF;
	localparam logic [RGBA_W-1:0] RST_THIRD   = 32'h00FF_00FF;
	localparam logic [RGBA_W-1:0] RST_FOURTH  = 32'h0000_FFFF;

	// colours seen by the datapath
	typedef struct packed {
		logic [RGBA_W-1:0]            dflt;
		logic [N_W-1:0][RGBA_W-1:0]   cols;
	} cfg_t;

	// one quotient to be formed
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} frac_t;

	// channel byte of a packed colour, red in the top byte
	function automatic logic [C_W-1:0] chan_of(input logic [RGBA_W-1:0] rgba, input int ch);
		return rgba[RGBA_W - C_W * (ch + 1) +: C_W];
	endfunction

endpackage

// ===== rtl/wcb_front.sv =====
// Front of the blender: products, sums and the numerator and denominator of each channel.
module wcb_front (
	input  logic                                       clk,
	input  logic [wcb_pkg::FRONT_ST-1:0]               en,
	input  logic [wcb_pkg::N_W-1:0][wcb_pkg::W_W-1:0]  weights,
	input  wcb_pkg::cfg_t                              cfg,
	output wcb_pkg::frac_t [wcb_pkg::N_CH-1:0]         frac
);
	import wcb_pkg::*;

	logic [N_CH-1:0][N_W-1:0][PROD_W-1:0] prod_s1;
	logic [SUM_W-1:0]                     sum_s1, sum_s2, sum_s3;
	logic [N_CH-1:0][ACC_W-1:0]           acc_s2;
	logic [CDEF_W-1:0]                    cdef_s2, cdef_s3;
	logic [DAC_W-1:0]                     dac_s3;
	logic [S255_W-1:0]                    s255_s3;
	logic [N_CH-2:0][A255_W-1:0]          acc255_s3;
	logic [ACC_W-1:0]                     acca_s3;
	frac_t [N_CH-1:0]                     frac_s4;
	logic [C_W-1:0]                       da;

	assign da = chan_of(cfg.dflt, CH_A);

	// stage 1: channel times weight, weight sum
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int ch = 0; ch < N_CH; ch++) begin
				for (int i = 0; i < N_W; i++) begin
					prod_s1[ch][i] <= PROD_W'(chan_of(cfg.cols[i], ch)) * PROD_W'(weights[i]);
				end
			end
			sum_s1 <= SUM_W'(weights[0]) + SUM_W'(weights[1])
				+ SUM_W'(weights[2]) + SUM_W'(weights[3]);
		end
	end

	// stage 2: product sums, default weight from the clamped sum
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int ch = 0; ch < N_CH; ch++) begin
				acc_s2[ch] <= ACC_W'(prod_s1[ch][0]) + ACC_W'(prod_s1[ch][1])
					+ ACC_W'(prod_s1[ch][2]) + ACC_W'(prod_s1[ch][3]);
			end
			sum_s2  <= sum_s1;
			cdef_s2 <= (sum_s1 >= SUM_W'(ONE_Q15)) ? '0 :
				CDEF_W'(SUM_W'(ONE_Q15) - sum_s1);
		end
	end

	// stage 3: default alpha times default weight, times-255 terms
	always_ff @(posedge clk) begin
		if (en[2]) begin
			dac_s3  <= DAC_W'(DAC_W'(da) * DAC_W'(cdef_s2));
			s255_s3 <= {sum_s2, {C_W{1'b0}}} - S255_W'(sum_s2);
			for (int ch = 0; ch < N_CH - 1; ch++) begin
				acc255_s3[ch] <= {acc_s2[ch], {C_W{1'b0}}} - A255_W'(acc_s2[ch]);
			end
			acca_s3 <= acc_s2[CH_A];
			sum_s3  <= sum_s2;
			cdef_s3 <= cdef_s2;
		end
	end

	// stage 4: numerators and denominators
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int ch = 0; ch < N_CH - 1; ch++) begin
				frac_s4[ch].num <= NUM_W'(NUM_W'(chan_of(cfg.dflt, ch)) * NUM_W'(dac_s3))
					+ NUM_W'(acc255_s3[ch]);
				frac_s4[ch].den <= DEN_W'(dac_s3) + DEN_W'(s255_s3);
			end
			frac_s4[CH_A].num <= NUM_W'(dac_s3) + NUM_W'(acca_s3);
			frac_s4[CH_A].den <= DEN_W'(cdef_s3) + DEN_W'(sum_s3);
		end
	end

	assign frac = frac_s4;

endmodule

// ===== rtl/wcb_div.sv =====
// Pipelined restoring divider: rounded quotient saturated to 8 bits, zero for a zero divisor.
module wcb_div (
	input  logic                        clk,
	input  logic [wcb_pkg::DIV_ST-1:0]  en,
	input  wcb_pkg::frac_t              frac,
	output logic [wcb_pkg::Q_W-1:0]     quo
);
	import wcb_pkg::*;

	logic [REM_W-1:0] rem_s  [0:DIV_ST-2];
	logic [DVS_W-1:0] dvs_s  [0:DIV_ST-2];
	logic             zero_s [0:DIV_ST-1];
	logic             sat_s  [1:DIV_ST-1];
	logic [Q_W-1:0]   q_s    [2:DIV_ST-1];

	// first stage: round-to-nearest form, floor((2n + d) / 2d)
	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_s[0]  <= REM_W'({frac.num, 1'b0}) + REM_W'(frac.den);
			dvs_s[0]  <= {frac.den, 1'b0};
			zero_s[0] <= (frac.den == '0);
		end
	end

	// second stage: quotient of 256 or more saturates
	always_ff @(posedge clk) begin
		if (en[1]) begin
			sat_s[1]  <= (rem_s[0] >= {dvs_s[0], {Q_W{1'b0}}});
			rem_s[1]  <= rem_s[0];
			dvs_s[1]  <= dvs_s[0];
			zero_s[1] <= zero_s[0];
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 2; k < DIV_ST; k++) begin : g_bit
		localparam int B = DIV_ST - 1 - k;
		logic [REM_W-1:0] trial;
		logic             ge;
		logic [Q_W-1:0]   q_in;

		assign trial = REM_W'(dvs_s[k-1]) << B;
		assign ge    = (rem_s[k-1] >= trial);

		if (k == 2) begin : g_first
			assign q_in = '0;
		end else begin : g_next
			assign q_in = q_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				q_s[k]    <= q_in | (Q_W'(ge) << B);
				sat_s[k]  <= sat_s[k-1];
				zero_s[k] <= zero_s[k-1];
			end
		end

		if (k < DIV_ST - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k] <= ge ? (rem_s[k-1] - trial) : rem_s[k-1];
					dvs_s[k] <= dvs_s[k-1];
				end
			end
		end
	end

	assign quo = zero_s[DIV_ST-1] ? '0 :
		(sat_s[DIV_ST-1] ? '1 : q_s[DIV_ST-1]);

endmodule

// ===== rtl/weighted_color_blend.sv =====
// Top level: weighted colour blender with configuration registers and stream ports.
//
// Input stream s_*: one item is four Q1.15 blend weights, 32768 meaning 1.0.
// Output stream m_*: one RGBA colour of four 8-bit channels per input item, in input order.
// Configuration channel cfg_*: index 0 default colour, 1..4 the colours of the
// four weights (red in bits 31..24, alpha in 7..0), 5 alpha enable. Indexes 6
// and 7 are ignored. cfg_ready is always high; write only while the block is idle.
//
// The pipeline has 15 register stages: four of products and sums, ten of the
// restoring divider (set-up, saturation check, one quotient bit per stage) and
// the output register.
// Throughput is one item per cycle while the receiver does not stall; the four
// channel dividers run side by side.
//
// Reset clears every stage valid bit and loads the register reset colours.
// When the receiver stalls, the pipeline keeps moving until its bubbles are
// squeezed out; s_tready drops only once every stage holds an item.
`include "weighted_color_blend_assert.svh"

module weighted_color_blend (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [wcb_pkg::S_DATA_W-1:0]    s_tdata,   // weight_one, weight_two, weight_three, weight_four
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [wcb_pkg::M_DATA_W-1:0]    m_tdata,   // red, green, blue, alpha
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wcb_pkg::IDX_W-1:0]       cfg_index,
	input  logic [wcb_pkg::RGBA_W-1:0]      cfg_data
);
	import wcb_pkg::*;

	logic [RGBA_W-1:0]         default_rgba_q;
	logic [N_W-1:0][RGBA_W-1:0] cols_q;
	logic                      alpha_enable_q;
	cfg_t                      cfg;

	logic [PIPE_ST-1:0]        v_q;
	logic [PIPE_ST-1:0]        en;
	frac_t [N_CH-1:0]          frac;
	logic [N_CH-1:0][Q_W-1:0]  quo;
	logic [M_DATA_W-1:0]       out_s15;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_rgba_q <= RST_DEFAULT;
			cols_q[0]      <= RST_FIRST;
			cols_q[1]      <= RST_SECOND;
			cols_q[2]      <= RST_THIRD;
			cols_q[3]      <= RST_FOURTH;
			alpha_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEFAULT:  default_rgba_q <= cfg_data;
				REG_FIRST:    cols_q[0]      <= cfg_data;
				REG_SECOND:   cols_q[1]      <= cfg_data;
				REG_THIRD:    cols_q[2]      <= cfg_data;
				REG_FOURTH:   cols_q[3]      <= cfg_data;
				REG_ALPHA_EN: alpha_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg.dflt  = default_rgba_q;
	assign cfg.cols  = cols_q;

	// a stage moves when it is empty or everything after it moves
	always_comb begin
		for (int k = 0; k < PIPE_ST; k++) begin
			en[k] = m_tready || ((v_q >> k) != ({PIPE_ST{1'b1}} >> k));
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int k = 1; k < PIPE_ST; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	wcb_front u_front (
		.clk     (clk),
		.en      (en[FRONT_ST-1:0]),
		.weights (s_tdata),
		.cfg     (cfg),
		.frac    (frac)
	);

	for (genvar ch = 0; ch < N_CH; ch++) begin : g_div
		wcb_div u_div (
			.clk  (clk),
			.en   (en[FRONT_ST+DIV_ST-1:FRONT_ST]),
			.frac (frac[ch]),
			.quo  (quo[ch])
		);
	end

	// output register, alpha forced opaque when blending is off
	always_ff @(posedge clk) begin
		if (en[PIPE_ST-1]) begin
			out_s15 <= {alpha_enable_q ? quo[CH_A] : {Q_W{1'b1}},
				quo[CH_B], quo[CH_G], quo[CH_R]};
		end
	end

	assign m_tvalid = v_q[PIPE_ST-1];
	assign m_tdata  = out_s15;

	`WCB_ASSERT(a_alpha_opaque, m_tvalid && !alpha_enable_q |-> m_tdata[31:24] == 8'hFF)
	`WCB_ASSERT(a_stall_only_full, !s_tready |-> (&v_q))
	`WCB_ASSERT(a_ready_follows, m_tready |-> s_tready)
	`WCB_ASSERT_RST(a_reset_empty, !arst_n |-> !m_tvalid && s_tready)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the weighted colour blender.
`timescale 1ns / 1ps

module tb_top;
	import wcb_pkg::*;

	// spare register indexes, writes to them must leave the colours alone
	localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int RAND_PHASES   = 10;
	localparam int PHASE_ITEMS   = 175;
	localparam int MAX_IDLE      = 10;
	localparam int REPORT_LIMIT  = 10;
	localparam int CYCLE_LIMIT   = 200000;

	logic                  clk;
	logic                  arst_n    = 1'b1;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;   // weight_one, weight_two, weight_three, weight_four
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;          // red, green, blue, alpha
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index = '0;
	logic [RGBA_W-1:0]     cfg_data  = '0;

	// own copy of the registers: 0 default colour, 1..4 weight colours
	logic [RGBA_W-1:0]     colour_reg [5];
	logic                  alpha_on;

	logic [S_DATA_W-1:0]   weight_q [$];
	logic [M_DATA_W-1:0]   blend_exp_q [$];

	// bit 0: sender never idles, bit 1: receiver never stalls
	logic [1:0]            pace_mode = 2'b00;
	int                    send_wait = 0;
	int                    recv_wait = 0;
	int                    stall_draw;
	int                    err_cnt   = 0;
	int                    cycle_cnt = 0;
	logic [M_DATA_W-1:0]   exp_rgba;
	string                 lane_name [4] = '{"red", "green", "blue", "alpha"};

	weighted_color_blend u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// channel byte of a packed colour; lane 0 red .. lane 3 alpha
	function automatic logic [C_W-1:0] lane_byte(input logic [RGBA_W-1:0] rgba, input int lane);
		return C_W'(rgba >> (8 * (3 - lane)));
	endfunction

	// quotient rounded to nearest, ties up, saturated to one byte
	function automatic logic [C_W-1:0] round_quot(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		if (den == 0)
			return '0;
		q = (2 * num + den) / (2 * den);
		return (q > 255) ? 8'hFF : q[C_W-1:0];
	endfunction

	// expected colour for one set of weights under the current registers
	function automatic logic [M_DATA_W-1:0] blend_predict(input logic [S_DATA_W-1:0] wts);
		logic [63:0]         w [4];
		logic [63:0]         wsum, cdef, da, cden, acc, num;
		logic [M_DATA_W-1:0] rgba;
		wsum = 0;
		for (int i = 0; i < N_W; i++) begin
			w[i] = 64'(wts[W_W*i +: W_W]);
			wsum += w[i];
		end
		cdef = ONE_Q15 - ((wsum > ONE_Q15) ? ONE_Q15 : wsum);
		da   = 64'(lane_byte(colour_reg[REG_DEFAULT], CH_A));
		// default colour counts with its own alpha
		cden = da * cdef + 255 * wsum;
		for (int ch = CH_R; ch <= CH_B; ch++) begin
			acc = 0;
			for (int i = 0; i < N_W; i++)
				acc += lane_byte(colour_reg[i+1], ch) * w[i];
			num = lane_byte(colour_reg[REG_DEFAULT], ch) * da * cdef + 255 * acc;
			rgba[C_W*ch +: C_W] = round_quot(num, cden);
		end
		if (alpha_on) begin
			num = da * cdef;
			for (int i = 0; i < N_W; i++)
				num += lane_byte(colour_reg[i+1], CH_A) * w[i];
			rgba[C_W*CH_A +: C_W] = round_quot(num, cdef + wsum);
		end else begin
			rgba[C_W*CH_A +: C_W] = 8'hFF;
		end
		return rgba;
	endfunction

	// random weights: mostly sums within one, some exact one, some wide values
	function automatic logic [S_DATA_W-1:0] rand_weights();
		logic [S_DATA_W-1:0] wts;
		int unsigned         left, pick, rot, kind;
		wts  = '0;
		left = ONE_Q15;
		rot  = $urandom_range(0, 3);
		kind = $urandom_range(0, 9);
		case (kind) inside
			[0:5]: begin
				for (int i = 0; i < N_W; i++) begin
					pick = (kind == 5 && i == N_W - 1) ? left : $urandom_range(0, left);
					wts[W_W*((i + rot) % N_W) +: W_W] = W_W'(pick);
					left -= pick;
				end
			end
			6: wts[W_W*rot +: W_W] = W_W'($urandom_range(0, 1) ? ONE_Q15 : ONE_Q15 + 1);
			7: begin
				for (int i = 0; i < N_W; i++)
					wts[W_W*i +: W_W] = W_W'($urandom_range(0, 255));
			end
			default: wts = {$urandom(), $urandom()};
		endcase
		return wts;
	endfunction

	// colour for a random phase; the first two phases take the extremes
	function automatic logic [RGBA_W-1:0] pick_colour(input int phase);
		if (phase == 0)
			return '0;
		if (phase == 1)
			return '1;
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return {24'($urandom_range(0, 32'hFF_FFFF)), 8'h00};
			default: return $urandom();
		endcase
	endfunction

	// one register write, mirrored into the local copy on transfer
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RGBA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx) inside
			[REG_DEFAULT:REG_FOURTH]: colour_reg[idx] = val;
			REG_ALPHA_EN: alpha_on = val[0];
			default: ;
		endcase
	endtask

	// wait until the sender is empty and every expected colour is back
	task automatic wait_idle();
		do @(negedge clk); while (weight_q.size() != 0 || s_tvalid || blend_exp_q.size() != 0);
	endtask

	// input side: one item per transfer, random gap after each unless pace_mode bit 0 is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			send_wait <= 0;
		end else begin
			if (s_tvalid && s_tready)
				blend_exp_q.push_back(blend_predict(s_tdata));
			if (!(s_tvalid && !s_tready)) begin
				if (send_wait > 0) begin
					s_tvalid  <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (weight_q.size() != 0) begin
					s_tdata   <= weight_q.pop_front();
					s_tvalid  <= 1'b1;
					send_wait <= pace_mode[0] ? 0 : $urandom_range(0, MAX_IDLE);
				end else begin
					s_tvalid  <= 1'b0;
				end
			end
		end
	end

	// output side: check each transfer against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (blend_exp_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= REPORT_LIMIT)
						$display("tb_top: colour %h arrived with nothing expected", m_tdata);
				end else begin
					exp_rgba = blend_exp_q.pop_front();
					for (int ch = 0; ch < N_CH; ch++) begin
						if (m_tdata[C_W*ch +: C_W] !== exp_rgba[C_W*ch +: C_W]) begin
							err_cnt++;
							if (err_cnt <= REPORT_LIMIT)
								$display("tb_top: %s expected %0d, got %0d", lane_name[ch],
									exp_rgba[C_W*ch +: C_W], m_tdata[C_W*ch +: C_W]);
						end
					end
				end
				stall_draw = pace_mode[1] ? 0 : $urandom_range(0, MAX_IDLE);
				m_tready  <= (stall_draw == 0);
				recv_wait <= stall_draw;
			end else if (recv_wait > 0) begin
				m_tready  <= (recv_wait == 1);
				recv_wait <= recv_wait - 1;
			end else begin
				m_tready  <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// stimulus: directed items, then random phases with fresh register settings
	initial begin
		// reset applied once every process waits on its events
		arst_n <= 1'b0;
		colour_reg[REG_DEFAULT] = RST_DEFAULT;
		colour_reg[REG_FIRST]   = RST_FIRST;
		colour_reg[REG_SECOND]  = RST_SECOND;
		colour_reg[REG_THIRD]   = RST_THIRD;
		colour_reg[REG_FOURTH]  = RST_FOURTH;
		alpha_on = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset colours, alpha off: each weight alone, sums below, at and above one
		@(negedge clk);
		weight_q.push_back({16'd0, 16'd0, 16'd0, 16'd0});
		weight_q.push_back({16'd0, 16'd0, 16'd0, 16'd32768});
		weight_q.push_back({16'd0, 16'd0, 16'd32768, 16'd0});
		weight_q.push_back({16'd0, 16'd32768, 16'd0, 16'd0});
		weight_q.push_back({16'd32768, 16'd0, 16'd0, 16'd0});
		weight_q.push_back({16'd32768, 16'd32768, 16'd32768, 16'd32768});
		weight_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		weight_q.push_back({16'd8192, 16'd8192, 16'd8192, 16'd8192});
		weight_q.push_back({16'd0, 16'd0, 16'd0, 16'd16384});
		weight_q.push_back({16'd0, 16'd0, 16'd0, 16'd1});
		weight_q.push_back({16'd0, 16'd0, 16'd0, 16'd32769});
		weight_q.push_back({16'hFF00, 16'h00FF, 16'h5555, 16'hAAAA});
		wait_idle();

		// default alpha zero with alpha on: all-zero weights give a zero colour divisor
		write_reg(REG_DEFAULT,  32'hC080_4000);
		write_reg(REG_FIRST,    32'h0000_0000);
		write_reg(REG_SECOND,   32'hFFFF_FFFF);
		write_reg(REG_THIRD,    32'h807F_01FE);
		write_reg(REG_FOURTH,   32'h0102_0304);
		write_reg(REG_ALPHA_EN, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0000_0000);
		@(negedge clk);
		weight_q.push_back({16'd0, 16'd0, 16'd0, 16'd0});
		weight_q.push_back({16'd0, 16'd0, 16'd0, 16'd1});
		weight_q.push_back({16'd0, 16'd0, 16'd16384, 16'd0});
		weight_q.push_back({16'd32768, 16'd0, 16'd0, 16'd0});
		weight_q.push_back({16'd8192, 16'd8192, 16'd8192, 16'd8192});
		weight_q.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		wait_idle();

		// random phases; the block is drained before every register change
		for (int p = 0; p < RAND_PHASES; p++) begin
			for (int r = REG_DEFAULT; r <= REG_FOURTH; r++)
				write_reg(r[IDX_W-1:0], pick_colour(p));
			write_reg(REG_ALPHA_EN, (p == 0) ? 32'h0000_0001 : $urandom());
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
			@(negedge clk);
			pace_mode = 2'(p % 4);
			for (int n = 0; n < PHASE_ITEMS; n++)
				weight_q.push_back(rand_weights());
			wait_idle();
		end

		repeat (PIPE_ST + 20) @(posedge clk);
		if (err_cnt == 0 && blend_exp_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/wcb_pkg.sv
rtl/wcb_front.sv
rtl/wcb_div.sv
rtl/weighted_color_blend.sv
tb/sv/tb_top.sv
